### rtl/core/msqe_pkg.sv
package msqe_pkg;

  // Sizing of the list set and the shared entry store
  localparam int NUM_LISTS  = 16;
  localparam int LIST_DEPTH = 32;
  localparam int WORD_WIDTH = 64;

  // Fixed field widths of the command and result ports
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 3;
  localparam int DATA_W   = 64;

  // Derived widths; LIST_DEPTH is a power of two so a ring slot wraps for free
  localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int PTR_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W  = PTR_W + 1;
  localparam int ADDR_W = LIST_W + PTR_W;
  localparam int STORE_DEPTH = NUM_LISTS * LIST_DEPTH;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE  = 2'd0,
    ACT_PUSH    = 2'd1,
    ACT_POP     = 2'd2,
    ACT_INVALID = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_MISSING = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4,
    ST_INVALID = 3'd5
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the command transaction
    logic exec;   // evaluate, update list tables, access the store
    logic fetch;  // move store read data into the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_hit;  // current command is a successful pop
  } dp_sts_t;

endpackage

### rtl/core/msqe_ctrl.sv
module msqe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output msqe_pkg::dp_cmd_t cmd_o,
  input  msqe_pkg::dp_sts_t sts_i
);
  import msqe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH
  } state_e;

  state_e state_q;
  logic   done_q;

  // Commands to the datapath follow the current state
  always_comb begin
    cmd_o.load  = start_i && (state_q == S_IDLE);
    cmd_o.exec  = (state_q == S_EXEC);
    cmd_o.fetch = (state_q == S_FETCH);
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  // State and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (sts_i.pop_hit) begin
            state_q <= S_FETCH;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        S_FETCH: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/msqe_dp.sv
module msqe_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  msqe_pkg::dp_cmd_t                 cmd_i,
  output msqe_pkg::dp_sts_t                 sts_o,
  input  logic [msqe_pkg::ACTION_W-1:0]     action_i,
  input  logic [msqe_pkg::INDEX_W-1:0]      list_index_i,
  input  logic                              make_stack_i,
  input  logic [msqe_pkg::DATA_W-1:0]       data_in_i,
  output logic [msqe_pkg::STATUS_W-1:0]     status_o,
  output logic [msqe_pkg::DATA_W-1:0]       data_out_o
);
  import msqe_pkg::*;

  // Captured command
  action_e                 act_q;
  logic [INDEX_W-1:0]      idx_q;
  logic                    mk_stack_q;
  logic [WORD_WIDTH-1:0]   word_q;

  // Per-list tables
  logic [NUM_LISTS-1:0]    exists_q;
  logic [NUM_LISTS-1:0]    is_stack_q;
  logic [PTR_W-1:0]        rd_ptr_q [NUM_LISTS];
  logic [CNT_W-1:0]        count_q  [NUM_LISTS];

  // Shared entry store, one ring region per list
  logic [WORD_WIDTH-1:0]   store_mem [STORE_DEPTH];
  logic [WORD_WIDTH-1:0]   rd_data_q;

  // Result registers
  status_e                 status_q;
  logic [WORD_WIDTH-1:0]   data_q;

  // Decode of the captured command
  logic                    bad_cmd;
  logic [LIST_W-1:0]       lidx;
  logic                    cur_exists;
  logic                    cur_stack;
  logic [PTR_W-1:0]        cur_ptr;
  logic [CNT_W-1:0]        cur_cnt;
  logic [PTR_W-1:0]        push_slot;
  logic [PTR_W-1:0]        pop_slot;
  status_e                 status_d;
  logic                    push_ok;
  logic                    pop_ok;
  logic                    create_ok;

  always_comb begin
    bad_cmd    = (act_q == ACT_INVALID) || (int'(idx_q) >= NUM_LISTS);
    lidx       = idx_q[LIST_W-1:0];
    cur_exists = exists_q[lidx];
    cur_stack  = is_stack_q[lidx];
    cur_ptr    = rd_ptr_q[lidx];
    cur_cnt    = count_q[lidx];
    push_slot  = cur_ptr + cur_cnt[PTR_W-1:0];
    pop_slot   = cur_stack ? PTR_W'(push_slot - PTR_W'(1)) : cur_ptr;

    status_d   = ST_OK;
    push_ok    = 1'b0;
    pop_ok     = 1'b0;
    create_ok  = 1'b0;
    if (bad_cmd) begin
      status_d = ST_INVALID;
    end else if (act_q == ACT_CREATE) begin
      if (cur_exists) begin
        status_d = ST_EXISTS;
      end else begin
        create_ok = 1'b1;
      end
    end else if (!cur_exists) begin
      status_d = ST_MISSING;
    end else if (act_q == ACT_PUSH) begin
      if (cur_cnt >= CNT_W'(LIST_DEPTH)) begin
        status_d = ST_FULL;
      end else begin
        push_ok = 1'b1;
      end
    end else begin
      if (cur_cnt == '0) begin
        status_d = ST_EMPTY;
      end else begin
        pop_ok = 1'b1;
      end
    end
  end

  assign sts_o.pop_hit = cmd_i.exec && pop_ok;

  // Command capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q      <= action_e'(action_i);
      idx_q      <= list_index_i;
      mk_stack_q <= make_stack_i;
      word_q     <= data_in_i[WORD_WIDTH-1:0];
    end
  end

  // List table updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exists_q   <= '0;
      is_stack_q <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        rd_ptr_q[i] <= '0;
        count_q[i]  <= '0;
      end
    end else if (cmd_i.exec) begin
      if (create_ok) begin
        exists_q[lidx]   <= 1'b1;
        is_stack_q[lidx] <= mk_stack_q;
        rd_ptr_q[lidx]   <= '0;
        count_q[lidx]    <= '0;
      end else if (push_ok) begin
        count_q[lidx] <= cur_cnt + CNT_W'(1);
      end else if (pop_ok) begin
        count_q[lidx] <= cur_cnt - CNT_W'(1);
        if (!cur_stack) begin
          rd_ptr_q[lidx] <= cur_ptr + PTR_W'(1);
        end
      end
    end
  end

  // Entry store: one write or one registered read per command
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_ok) begin
      store_mem[{lidx, push_slot}] <= word_q;
    end
    if (cmd_i.exec && pop_ok) begin
      rd_data_q <= store_mem[{lidx, pop_slot}];
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      data_q   <= '0;
    end else if (cmd_i.fetch) begin
      data_q <= rd_data_q;
    end
  end

  assign status_o   = status_q;
  assign data_out_o = DATA_W'(data_q);

endmodule

### rtl/core/multi_stack_queue_engine.sv
// Sequence: start_i accepted in idle captures the command and the exec state evaluates it;
//   done_o follows exec, or the fetch state for a pop that returns a word (registered read).
// A new command is accepted only once the sequencer is back in idle (busy_o low).
//   done_o lasts one cycle and cannot be stalled.
// Reset (rst_ni low, async): all lists cleared to not created, empty; store contents
//   are left as they are and are never read before a push writes them.
module multi_stack_queue_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [msqe_pkg::ACTION_W-1:0]     action_i,
  input  logic [msqe_pkg::INDEX_W-1:0]      list_index_i,
  input  logic                              make_stack_i,
  input  logic [msqe_pkg::DATA_W-1:0]       data_in_i,
  output logic                              done_o,
  output logic [msqe_pkg::STATUS_W-1:0]     status_o,
  output logic [msqe_pkg::DATA_W-1:0]       data_out_o
);
  import msqe_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer
  msqe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (dp_cmd),
    .sts_i   (dp_sts)
  );

  // List tables, entry store and result registers
  msqe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .action_i     (action_i),
    .list_index_i (list_index_i),
    .make_stack_i (make_stack_i),
    .data_in_i    (data_in_i),
    .status_o     (status_o),
    .data_out_o   (data_out_o)
  );

endmodule

### verif/list_result_checker.sv
`timescale 1ns / 1ps

// Watches the command and result channels of the list engine, predicts each
// result from its own copy of the list tables and compares in order.
module list_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [msqe_pkg::ACTION_W-1:0] action_i,
  input  logic [msqe_pkg::INDEX_W-1:0]  list_index_i,
  input  logic                          make_stack_i,
  input  logic [msqe_pkg::DATA_W-1:0]   data_in_i,
  input  logic                          done_i,
  input  logic [msqe_pkg::STATUS_W-1:0] status_i,
  input  logic [msqe_pkg::DATA_W-1:0]   data_out_i,
  output int                            err_count_o,
  output int                            pending_o
);
  import msqe_pkg::*;

  typedef struct {
    status_e           status;
    logic [DATA_W-1:0] word;
  } list_result_t;

  localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - WORD_WIDTH);

  // Shadow copy of the list tables and the shared entry store
  logic              list_live  [NUM_LISTS];
  logic              list_lifo  [NUM_LISTS];
  logic [PTR_W-1:0]  head_ptr   [NUM_LISTS];
  logic [CNT_W-1:0]  fill_level [NUM_LISTS];
  logic [DATA_W-1:0] word_store [STORE_DEPTH];

  list_result_t expected_results [$];
  int           mismatches = 0;

  // Applies one command to the shadow tables and returns its result
  function automatic list_result_t run_command(action_e act, int idx, logic lifo,
                                               logic [DATA_W-1:0] word);
    list_result_t res;
    int           slot;
    res.status = ST_OK;
    res.word   = '0;
    if (act == ACT_INVALID || idx >= NUM_LISTS) begin
      res.status = ST_INVALID;
    end else if (act == ACT_CREATE) begin
      if (list_live[idx]) begin
        res.status = ST_EXISTS;
      end else begin
        list_live[idx]  = 1'b1;
        list_lifo[idx]  = lifo;
        head_ptr[idx]   = '0;
        fill_level[idx] = '0;
      end
    end else if (!list_live[idx]) begin
      res.status = ST_MISSING;
    end else if (act == ACT_PUSH) begin
      if (int'(fill_level[idx]) >= LIST_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // new word goes right behind the newest one in the ring
        slot = idx * LIST_DEPTH + (int'(head_ptr[idx]) + int'(fill_level[idx])) % LIST_DEPTH;
        word_store[slot] = word & WORD_MASK;
        fill_level[idx]  = fill_level[idx] + 1'b1;
      end
    end else if (fill_level[idx] == '0) begin
      res.status = ST_EMPTY;
    end else if (list_lifo[idx]) begin
      // stack: take the newest entry, head stays put
      slot = idx * LIST_DEPTH +
             (int'(head_ptr[idx]) + int'(fill_level[idx]) - 1) % LIST_DEPTH;
      res.word        = word_store[slot] & WORD_MASK;
      fill_level[idx] = fill_level[idx] - 1'b1;
    end else begin
      // queue: take the oldest entry and advance the head
      slot = idx * LIST_DEPTH + int'(head_ptr[idx]);
      res.word        = word_store[slot] & WORD_MASK;
      head_ptr[idx]   = PTR_W'((int'(head_ptr[idx]) + 1) % LIST_DEPTH);
      fill_level[idx] = fill_level[idx] - 1'b1;
    end
    return res;
  endfunction

  // Predict on each accepted command, compare on each result strobe
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_res;
    list_result_t new_res;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        list_live[i]  = 1'b0;
        list_lifo[i]  = 1'b0;
        head_ptr[i]   = '0;
        fill_level[i] = '0;
      end
      expected_results.delete();
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: status=%0d data_out=%h",
                   $time, status_i, data_out_i);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          if (status_i !== exp_res.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_res.status, status_i);
            mismatches++;
          end
          if (data_out_i !== exp_res.word) begin
            $display("%0t: data_out mismatch: expected %h, actual %h",
                     $time, exp_res.word, data_out_i);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) begin
        new_res = run_command(action_e'(action_i), int'(list_index_i),
                              make_stack_i, data_in_i);
        expected_results.insert(expected_results.size(), new_res);
      end
      err_count_o <= mismatches;
      pending_o   <= expected_results.size();
    end
  end

endmodule

### verif/tb_multi_stack_queue_engine.sv
`timescale 1ns / 1ps

module tb_multi_stack_queue_engine;
  import msqe_pkg::*;

  localparam int N_ITEMS     = 600;
  localparam int CYCLE_LIMIT = 200000;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                start_i      = 1'b0;
  logic                busy_o;
  logic [ACTION_W-1:0] action_i     = '0;
  logic [INDEX_W-1:0]  list_index_i = '0;
  logic                make_stack_i = 1'b0;
  logic [DATA_W-1:0]   data_in_i    = '0;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [DATA_W-1:0]   data_out_o;

  int err_count;
  int pending;
  int issued    = 0;
  int idle_pct  = 0;
  int cycle_cnt = 0;

  multi_stack_queue_engine i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .list_index_i (list_index_i),
    .make_stack_i (make_stack_i),
    .data_in_i    (data_in_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .data_out_o   (data_out_o)
  );

  list_result_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .action_i     (action_i),
    .list_index_i (list_index_i),
    .make_stack_i (make_stack_i),
    .data_in_i    (data_in_i),
    .done_i       (done_o),
    .status_i     (status_o),
    .data_out_i   (data_out_o),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one command, with an optional gap first, and hold it until accepted.
  // busy is sampled mid-cycle so the accept decision matches the block's edge.
  task automatic issue_command(action_e act, logic [INDEX_W-1:0] idx, logic lifo,
                               logic [DATA_W-1:0] word);
    bit free_slot;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    action_i     <= act;
    list_index_i <= idx;
    make_stack_i <= lifo;
    data_in_i    <= word;
    do begin
      @(negedge clk_i);
      free_slot = !busy_o;
      @(posedge clk_i);
    end while (!free_slot);
    issued++;
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Create a list, overfill it, then drain it past empty; queues wrap their head
  task automatic fill_and_drain(logic [INDEX_W-1:0] idx);
    issue_command(ACT_CREATE, idx, 1'($urandom_range(1)), rand_word());
    repeat (LIST_DEPTH + 1) issue_command(ACT_PUSH, idx, 1'($urandom_range(1)), rand_word());
    repeat (LIST_DEPTH + 1) issue_command(ACT_POP, idx, 1'($urandom_range(1)), rand_word());
  endtask

  // Short push run followed by as many pops on one list
  task automatic push_pop_run(logic [INDEX_W-1:0] idx, int len);
    repeat (len) issue_command(ACT_PUSH, idx, 1'($urandom_range(1)), rand_word());
    repeat (len) issue_command(ACT_POP, idx, 1'($urandom_range(1)), rand_word());
  endtask

  task automatic random_command();
    int      pick;
    action_e act;
    pick = $urandom_range(99);
    if (pick < 8)       act = ACT_CREATE;
    else if (pick < 53) act = ACT_PUSH;
    else if (pick < 93) act = ACT_POP;
    else                act = ACT_INVALID;
    issue_command(act, INDEX_W'($urandom_range(NUM_LISTS - 1)), 1'($urandom_range(1)),
                  rand_word());
  endtask

  initial begin
    int pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: invalid commands, missing lists, duplicate create, empty pops,
    // extreme words through a queue and a stack
    idle_pct = 11;
    issue_command(ACT_INVALID, 4'd0, 1'b1, '1);
    issue_command(ACT_INVALID, 4'd15, 1'b0, '0);
    issue_command(ACT_PUSH, 4'd3, 1'b0, 64'h0123_4567_89ab_cdef);
    issue_command(ACT_POP, 4'd3, 1'b1, '0);
    issue_command(ACT_CREATE, 4'd0, 1'b0, '0);
    issue_command(ACT_CREATE, 4'd0, 1'b1, '1);
    issue_command(ACT_CREATE, 4'd15, 1'b1, '0);
    issue_command(ACT_POP, 4'd0, 1'b0, '0);
    issue_command(ACT_POP, 4'd15, 1'b0, '0);
    issue_command(ACT_PUSH, 4'd0, 1'b0, '0);
    issue_command(ACT_PUSH, 4'd0, 1'b1, '1);
    issue_command(ACT_PUSH, 4'd0, 1'b0, {16{4'ha}});
    issue_command(ACT_PUSH, 4'd0, 1'b0, {16{4'h5}});
    issue_command(ACT_PUSH, 4'd15, 1'b0, '1);
    issue_command(ACT_PUSH, 4'd15, 1'b1, '0);
    issue_command(ACT_PUSH, 4'd15, 1'b0, {16{4'h5}});
    issue_command(ACT_POP, 4'd0, 1'b0, '1);
    issue_command(ACT_POP, 4'd0, 1'b1, '0);
    issue_command(ACT_POP, 4'd15, 1'b0, '0);
    issue_command(ACT_POP, 4'd15, 1'b0, '1);
    issue_command(ACT_INVALID, 4'd0, 1'b0, '1);
    issue_command(ACT_POP, 4'd0, 1'b0, '0);
    issue_command(ACT_POP, 4'd0, 1'b0, '0);
    issue_command(ACT_POP, 4'd0, 1'b0, '0);

    // Random phases: sender gaps rare, then frequent, then none
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 11 : (ph == 1) ? 67 : 0;
      fill_and_drain(INDEX_W'($urandom_range(NUM_LISTS - 1)));
      while (issued < (ph + 1) * N_ITEMS / 3) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          push_pop_run(INDEX_W'($urandom_range(NUM_LISTS - 1)), $urandom_range(1, 8));
        end else begin
          random_command();
        end
      end
    end

    // Drain outstanding results, then give the verdict
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
